### design/imuct_pkg.sv
// ----------------------------------------------------------------------------
// imuct_pkg: shared definitions for the IMU complementary tilt filter
// Constants, register and operation codes, the arctangent table and the
// saturation helper used by the filter and its CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imuct_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET = 1'd1;
  localparam int unsigned CFG_DATA_W = 19;

  // Sample kinds
  localparam logic OP_GYRO  = 1'b0;
  localparam logic OP_ACCEL = 1'b1;

  // Register reset values
  localparam logic [16:0]        ALPHA_RESET = 17'd655;
  localparam logic signed [18:0] ROFF_RESET  = -19'sd13726;

  // Fixed point constants
  localparam logic [16:0]        ONE_Q16   = 17'd65536;
  localparam logic signed [31:0] YAW_INIT  = 32'sd205881;
  localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
  localparam logic [63:0]        GYRO_CAP  = 64'd1099511627776;
  localparam logic [10:0]        DIV_K     = 11'd1000;

  // CORDIC configuration
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_IDX_W       = 5;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the 32 bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/imuct_cordic.sv
// ----------------------------------------------------------------------------
// imuct_cordic: iterative atan2 unit
// Folds the vector into the right half plane, normalizes it one bit per
// cycle, then runs one vectoring step per cycle and rounds to Q3.16.
// ----------------------------------------------------------------------------
`default_nettype none

module imuct_cordic #(
  parameter int unsigned STEPS = imuct_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] x_i,
  output logic                    done_o,
  output logic signed [19:0]      angle_o
);

  localparam int unsigned IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [IW-1:0] LAST_I = IW'(STEPS - 1);
  localparam logic [47:0] NORM_LIM = 48'd274877906944;
  localparam int unsigned ATAN_W = imuct_pkg::ATAN_IDX_W;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IW-1:0]      i_q;
  logic signed [47:0] x_q, y_q;
  logic signed [35:0] z_q, off_q;

  logic signed [47:0] xs, ys, dx, dy;
  logic [47:0]        ay, mag;
  logic               norm_more, ypos;
  logic signed [35:0] atn, sum;

  // Magnitude test for normalization
  always_comb begin
    xs = {{14{x_i[33]}}, x_i};
    ys = {{14{y_i[33]}}, y_i};
    ay = y_q[47] ? 48'(-y_q) : 48'(y_q);
    mag = (48'(x_q) > ay) ? 48'(x_q) : ay;
    norm_more = (mag != 48'd0) && (mag < NORM_LIM);
    dx = x_q >>> i_q;
    dy = y_q >>> i_q;
    ypos = !y_q[47] && (y_q != 48'sd0);
    atn = $signed({6'd0, imuct_pkg::atan_q30(ATAN_W'(i_q))});
    sum = z_q + off_q + 36'sd8192;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: if (start_i) state_d = C_NORM;
      C_NORM: if (!norm_more) state_d = C_ITER;
      C_ITER: if (i_q == LAST_I) state_d = C_DONE;
      C_DONE: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == C_ITER) begin
        i_q <= i_q + IW'(1);
      end else begin
        i_q <= '0;
      end
    end
  end

  // Rotation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        z_q <= '0;
        if (x_i < 0) begin
          off_q <= (y_i >= 0) ? imuct_pkg::PI_Q30 : -imuct_pkg::PI_Q30;
          x_q   <= -xs;
          y_q   <= -ys;
        end else begin
          off_q <= '0;
          x_q   <= xs;
          y_q   <= ys;
        end
      end
      C_NORM: begin
        if (norm_more) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      C_ITER: begin
        if (ypos) begin
          x_q <= x_q + dy;
          y_q <= y_q - dx;
          z_q <= z_q + atn;
        end else begin
          x_q <= x_q - dy;
          y_q <= y_q + dx;
          z_q <= z_q - atn;
        end
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  assign done_o  = (state_q == C_DONE);
  assign angle_o = sum[33:14];

endmodule

`default_nettype wire

### design/imu_complementary_tilt_filter.sv
// Sequence: a gyro sample runs rate, multiply, divide and accumulate per axis,
// or goes straight to the output before the first accel sample; an accel sample
// runs squares, square root, two normalizing CORDIC arctangents, then the blend once initialized.
// Throughput: one sample at a time; the sequencer, its shared 33x33 multiplier,
// the bit-serial square root and the 4-bit-per-cycle divide by 1000 set it.
// Reset: asynchronous, active low; angles zero, uninitialized, register defaults.
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter: tilt filter from gyro and accel samples
// Integrates gyro rates over time and blends in accelerometer tilt angles
// computed with a shared CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = imuct_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [143:0]                         s_axis_tdata,  // sample_x, sample_y, sample_z, timestamp_us
  input  wire logic [0:0]                           s_axis_tuser,  // operation
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [95:0]                               m_axis_tdata,  // angle_x, angle_y, angle_z
  output logic [0:0]                                m_axis_tuser,  // initialized
  input  wire logic                                 cfg_we_i,
  input  wire logic [imuct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [imuct_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_G_ABS  = 5'd1;
  localparam logic [4:0] S_G_RATE = 5'd2;
  localparam logic [4:0] S_G_MHI  = 5'd3;
  localparam logic [4:0] S_G_MLO  = 5'd4;
  localparam logic [4:0] S_G_SUM  = 5'd5;
  localparam logic [4:0] S_G_DIV  = 5'd6;
  localparam logic [4:0] S_G_ACC  = 5'd7;
  localparam logic [4:0] S_A_SQY  = 5'd8;
  localparam logic [4:0] S_A_SQZ  = 5'd9;
  localparam logic [4:0] S_A_SUM  = 5'd10;
  localparam logic [4:0] S_A_SQRT = 5'd11;
  localparam logic [4:0] S_A_CR1  = 5'd12;
  localparam logic [4:0] S_A_CW1  = 5'd13;
  localparam logic [4:0] S_A_CR2  = 5'd14;
  localparam logic [4:0] S_A_CW2  = 5'd15;
  localparam logic [4:0] S_A_SET  = 5'd16;
  localparam logic [4:0] S_B_MA   = 5'd17;
  localparam logic [4:0] S_B_MB   = 5'd18;
  localparam logic [4:0] S_B_ADD  = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  // Control and state registers
  logic [4:0]         state_q, state_d;
  logic [1:0]         gk_q;
  logic               bk_q;
  logic [3:0]         cnt_q;
  logic signed [31:0] ang_x_q, ang_y_q, ang_z_q;
  logic               awaiting_q;
  logic [47:0]        last_gyro_q;
  logic [16:0]        alpha_q;
  logic signed [18:0] roff_q;

  // Payload registers
  logic signed [31:0] sx_q, sy_q, sz_q;
  logic               op_q;
  logic signed [47:0] delta_q;
  logic [47:0]        bmag_q;
  logic [31:0]        rabs_q;
  logic               rneg_q;
  logic signed [65:0] prod_q;
  logic [47:0]        phi_q;
  logic               cap_q;
  logic [63:0]        div_q;
  logic [9:0]         rem_q;
  logic [63:0]        sq_q, res_q, bit_q;
  logic signed [31:0] roll_q, pitch_q;
  logic signed [49:0] tmp_q;

  logic               in_xfer, out_free;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] rate_sel, old_sel, acc_sel, ang_sel, ang_new;
  logic [16:0]        alpha_c, alpha_n;
  logic [9:0]         rem_n;
  logic [10:0]        dtry;
  logic [3:0]         qbits;
  logic [40:0]        qv;
  logic signed [43:0] inc, gsum;
  logic [63:0]        sqt;
  logic signed [49:0] bsum;
  logic               cr_start, cr_done;
  logic signed [33:0] cr_y, cr_x;
  logic signed [19:0] cr_angle;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Operand selection for the shared multiplier and small helpers
  always_comb begin
    alpha_c  = (alpha_q > imuct_pkg::ONE_Q16) ? imuct_pkg::ONE_Q16 : alpha_q;
    alpha_n  = imuct_pkg::ONE_Q16 - alpha_c;
    old_sel  = bk_q ? ang_z_q : ang_x_q;
    acc_sel  = bk_q ? roll_q : pitch_q;
    case (gk_q)
      2'd0:    begin rate_sel = sz_q; ang_sel = ang_x_q; end
      2'd1:    begin rate_sel = sy_q; ang_sel = ang_y_q; end
      default: begin rate_sel = sx_q; ang_sel = ang_z_q; end
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_G_MHI: begin
        mul_a = {1'b0, rabs_q};
        mul_b = {17'd0, bmag_q[47:32]};
      end
      S_G_MLO: begin
        mul_a = {1'b0, rabs_q};
        mul_b = {1'b0, bmag_q[31:0]};
      end
      S_A_SQY: begin
        mul_a = {sy_q[31], sy_q};
        mul_b = {sy_q[31], sy_q};
      end
      S_A_SQZ: begin
        mul_a = {sz_q[31], sz_q};
        mul_b = {sz_q[31], sz_q};
      end
      S_B_MA: begin
        mul_a = {old_sel[31], old_sel};
        mul_b = {16'd0, alpha_c};
      end
      S_B_MB: begin
        mul_a = {acc_sel[31], acc_sel};
        mul_b = {16'd0, alpha_n};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Four restoring steps of the divide by 1000
  always_comb begin
    rem_n = rem_q;
    qbits = '0;
    for (int j = 0; j < 4; j++) begin
      dtry = {rem_n, div_q[63-j]};
      if (dtry >= imuct_pkg::DIV_K) begin
        dtry = dtry - imuct_pkg::DIV_K;
        qbits[3-j] = 1'b1;
      end
      rem_n = dtry[9:0];
    end
  end

  // Gyro increment, square root step and blend sum
  always_comb begin
    qv = (cap_q || (div_q > imuct_pkg::GYRO_CAP)) ? imuct_pkg::GYRO_CAP[40:0] : div_q[40:0];
    inc = (rneg_q ^ delta_q[47]) ? -$signed({3'd0, qv}) : $signed({3'd0, qv});
    gsum = (gk_q == 2'd2) ? ({{12{ang_sel[31]}}, ang_sel} + inc)
                          : ({{12{ang_sel[31]}}, ang_sel} - inc);
    ang_new = imuct_pkg::sat32({{20{gsum[43]}}, gsum});
    sqt  = res_q + bit_q;
    bsum = tmp_q + $signed(prod_q[49:0]) + 50'sd32768;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser[0] == imuct_pkg::OP_ACCEL) state_d = S_A_SQY;
          else if (awaiting_q) state_d = S_DONE;
          else state_d = S_G_ABS;
        end
      end
      S_G_ABS:  state_d = S_G_RATE;
      S_G_RATE: state_d = S_G_MHI;
      S_G_MHI:  state_d = S_G_MLO;
      S_G_MLO:  state_d = S_G_SUM;
      S_G_SUM:  state_d = S_G_DIV;
      S_G_DIV:  if (cnt_q == 4'd15) state_d = S_G_ACC;
      S_G_ACC:  state_d = (gk_q == 2'd2) ? S_DONE : S_G_RATE;
      S_A_SQY:  state_d = S_A_SQZ;
      S_A_SQZ:  state_d = S_A_SUM;
      S_A_SUM:  state_d = S_A_SQRT;
      S_A_SQRT: if (bit_q[0]) state_d = S_A_CR1;
      S_A_CR1:  state_d = S_A_CW1;
      S_A_CW1:  if (cr_done) state_d = S_A_CR2;
      S_A_CR2:  state_d = S_A_CW2;
      S_A_CW2:  if (cr_done) state_d = S_A_SET;
      S_A_SET:  state_d = awaiting_q ? S_DONE : S_B_MA;
      S_B_MA:   state_d = S_B_MB;
      S_B_MB:   state_d = S_B_ADD;
      S_B_ADD:  state_d = bk_q ? S_DONE : S_B_MA;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state, filter state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      gk_q          <= '0;
      bk_q          <= 1'b0;
      cnt_q         <= '0;
      ang_x_q       <= '0;
      ang_y_q       <= '0;
      ang_z_q       <= '0;
      awaiting_q    <= 1'b1;
      last_gyro_q   <= '0;
      alpha_q       <= imuct_pkg::ALPHA_RESET;
      roff_q        <= imuct_pkg::ROFF_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          imuct_pkg::REG_BLEND_ALPHA: alpha_q <= cfg_data_i[16:0];
          imuct_pkg::REG_ROLL_OFFSET: roff_q  <= $signed(cfg_data_i);
          default: alpha_q <= alpha_q;
        endcase
      end
      // record gyro time on every gyro transfer
      if (in_xfer && (s_axis_tuser[0] == imuct_pkg::OP_GYRO)) begin
        last_gyro_q <= s_axis_tdata[143:96];
      end
      case (state_q)
        S_IDLE: begin
          gk_q <= '0;
          bk_q <= 1'b0;
        end
        S_G_SUM: cnt_q <= '0;
        S_G_DIV: cnt_q <= cnt_q + 4'd1;
        S_G_ACC: begin
          case (gk_q)
            2'd0:    ang_x_q <= ang_new;
            2'd1:    ang_y_q <= ang_new;
            default: ang_z_q <= ang_new;
          endcase
          gk_q <= gk_q + 2'd1;
        end
        S_A_SET: begin
          if (awaiting_q) begin
            awaiting_q <= 1'b0;
            ang_x_q    <= pitch_q;
            ang_y_q    <= imuct_pkg::YAW_INIT;
            ang_z_q    <= roll_q;
          end
        end
        S_B_ADD: begin
          if (bk_q) ang_z_q <= imuct_pkg::sat32($signed({{14{bsum[49]}}, bsum}) >>> 16);
          else ang_x_q <= imuct_pkg::sat32($signed({{14{bsum[49]}}, bsum}) >>> 16);
          bk_q <= 1'b1;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
      // output register
      if (state_q == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_xfer) begin
      op_q    <= s_axis_tuser[0];
      sx_q    <= s_axis_tdata[31:0];
      sy_q    <= s_axis_tdata[63:32];
      sz_q    <= s_axis_tdata[95:64];
      delta_q <= s_axis_tdata[143:96] - last_gyro_q;
    end
    case (state_q)
      S_G_ABS:  bmag_q <= delta_q[47] ? 48'(-delta_q) : 48'(delta_q);
      S_G_RATE: begin
        rneg_q <= rate_sel[31];
        rabs_q <= rate_sel[31] ? 32'(-rate_sel) : 32'(rate_sel);
      end
      S_G_MLO:  phi_q <= prod_q[47:0];
      S_G_SUM: begin
        cap_q <= |phi_q[47:30];
        div_q <= {phi_q[31:0], 32'd0} + prod_q[63:0];
        rem_q <= '0;
      end
      S_G_DIV: begin
        div_q <= {div_q[59:0], qbits};
        rem_q <= rem_n;
      end
      S_A_SQZ:  sq_q <= prod_q[63:0];
      S_A_SUM: begin
        sq_q  <= sq_q + prod_q[63:0];
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      S_A_SQRT: begin
        if (sq_q >= sqt) begin
          sq_q  <= sq_q - sqt;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_A_CW1: if (cr_done) roll_q <= 32'(cr_angle) + 32'(roff_q);
      S_A_CW2: if (cr_done) pitch_q <= 32'(cr_angle);
      S_B_MB:  tmp_q <= prod_q[49:0];
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {ang_z_q, ang_y_q, ang_x_q};
          m_axis_tuser <= !awaiting_q;
        end
      end
      default: begin
        tmp_q <= tmp_q;
      end
    endcase
  end

  // Shared atan2 unit: roll first, then pitch from the magnitude
  assign cr_start = (state_q == S_A_CR1) || (state_q == S_A_CR2);
  assign cr_y = (state_q == S_A_CR1) ? 34'(sy_q) : 34'(sx_q);
  assign cr_x = (state_q == S_A_CR1) ? 34'(sz_q) : $signed({2'b00, res_q[31:0]});

  imuct_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cr_start),
    .y_i     (cr_y),
    .x_i     (cr_x),
    .done_o  (cr_done),
    .angle_o (cr_angle)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("accepted sample did not start the sequencer");
  a_init_flag_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (m_axis_tuser[0] == !awaiting_q))
    else $error("initialized flag disagrees with filter state");
  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q |=> !awaiting_q)
    else $error("filter fell back to uninitialized");
  a_gyro_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_G_ACC) |-> (op_q == imuct_pkg::OP_GYRO && !awaiting_q))
    else $error("gyro integration on a non-gyro sample");
`endif

endmodule

`default_nettype wire

### sim/imu_tilt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_tilt_checker: angle predictor and result scoreboard
// Watches the sample, result and register channels of the tilt filter, models
// the filter's fixed point behavior for every accepted sample and compares
// each result transfer, field by field, with the oldest predicted angle set.
// ----------------------------------------------------------------------------
module imu_tilt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tready_i,
  input  logic [143:0]  s_tdata_i,   // sample_x, sample_y, sample_z, timestamp_us
  input  logic [0:0]    s_tuser_i,   // operation
  input  logic          m_tvalid_i,
  input  logic          m_tready_i,
  input  logic [95:0]   m_tdata_i,   // angle_x, angle_y, angle_z
  input  logic [0:0]    m_tuser_i,   // initialized
  input  logic          cfg_we_i,
  input  logic [imuct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [imuct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);
  import imuct_pkg::*;

  localparam int      STEPS    = 16;
  localparam longint  HALF_PI2 = 64'sd3373259426;  // pi in Q2.30
  localparam longint  YAW0     = 64'sd205881;
  localparam longint  INC_CAP  = 64'sd1099511627776;

  typedef struct {
    logic signed [31:0] ang[3];
    logic               init;
  } angle_set_t;

  localparam longint ATAN_TBL[16] = '{
    843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767
  };

  angle_set_t         angle_q[$];
  logic signed [31:0] tilt[3];
  logic               waiting_accel;
  logic [47:0]        gyro_stamp;
  logic [16:0]        alpha;
  logic signed [18:0] roll_trim;

  assign pending_o = angle_q.size();

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // CORDIC vectoring arctangent, Q15.16 result
  function automatic longint arc_tan2(input longint y, input longint x);
    longint off, z, dx, dy, ay, m;
    off = 0;
    z = 0;
    if (x < 0) begin
      off = (y >= 0) ? HALF_PI2 : -HALF_PI2;
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m != 0 && m < 64'sd274877906944) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += ATAN_TBL[i];
      end else begin
        x -= dy; y += dx; z -= ATAN_TBL[i];
      end
    end
    return (z + off + 8192) >>> 14;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rate * dt / 1000, toward zero, capped at 2^40
  function automatic longint rate_step(input longint rate, input longint dt);
    logic neg;
    longint unsigned a, b, phi, q;
    neg = (rate < 0) != (dt < 0);
    a = (rate < 0) ? -rate : rate;
    b = (dt < 0) ? -dt : dt;
    phi = a * (b >> 32);
    if (phi >= (64'd1 << 30)) begin
      q = INC_CAP;
    end else begin
      q = ((phi << 32) + a * (b & 64'hffff_ffff)) / 1000;
      if (q > INC_CAP) q = INC_CAP;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] mix(input longint old, input longint acc);
    longint a;
    a = alpha;
    if (a > 65536) a = 65536;
    return clamp32((old * a + acc * (65536 - a) + 32768) >>> 16);
  endfunction

  // Advance the model by one sample and queue the angles it yields
  task automatic predict_sample(input logic op, input logic [143:0] d);
    longint sx, sy, sz, dt, mag, roll, pitch;
    angle_set_t e;
    sx = longint'($signed(d[31:0]));
    sy = longint'($signed(d[63:32]));
    sz = longint'($signed(d[95:64]));
    if (op == OP_GYRO) begin
      if (!waiting_accel) begin
        dt = longint'($signed(d[143:96] - gyro_stamp));
        tilt[0] = clamp32(longint'(tilt[0]) - rate_step(sz, dt));
        tilt[1] = clamp32(longint'(tilt[1]) - rate_step(sy, dt));
        tilt[2] = clamp32(longint'(tilt[2]) + rate_step(sx, dt));
      end
      gyro_stamp = d[143:96];
    end else begin
      mag = int_sqrt(longint'(sy * sy) + longint'(sz * sz));
      roll = clamp32(arc_tan2(sy, sz) + longint'(roll_trim));
      pitch = clamp32(arc_tan2(sx, mag));
      if (waiting_accel) begin
        waiting_accel = 1'b0;
        tilt[0] = pitch;
        tilt[1] = YAW0;
        tilt[2] = roll;
      end else begin
        tilt[0] = mix(tilt[0], pitch);
        tilt[2] = mix(tilt[2], roll);
      end
    end
    e.ang = tilt;
    e.init = !waiting_accel;
    angle_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    angle_set_t e;
    if (!rst_ni) begin
      tilt = '{0, 0, 0};
      waiting_accel = 1'b1;
      gyro_stamp = '0;
      alpha = ALPHA_RESET;
      roll_trim = ROFF_RESET;
      fail_count_o = 0;
      angle_q.delete();
    end else begin
      // track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BLEND_ALPHA) alpha = cfg_data_i[16:0];
        else if (cfg_idx_i == REG_ROLL_OFFSET) roll_trim = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) predict_sample(s_tuser_i[0], s_tdata_i);
      // compare result transfer against oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h / %b",
                   $time, m_tdata_i, m_tuser_i);
          fail_count_o++;
        end else begin
          e = angle_q.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (m_tdata_i[32*k +: 32] !== e.ang[k]) begin
              $display("%0t: angle %0d mismatch, expected %0d, actual %0d", $time, k,
                       e.ang[k], $signed(m_tdata_i[32*k +: 32]));
              fail_count_o++;
            end
          end
          if (m_tuser_i[0] !== e.init) begin
            $display("%0t: initialized mismatch, expected %b, actual %b",
                     $time, e.init, m_tuser_i[0]);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

### sim/imu_complementary_tilt_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_tb: stimulus and verdict for the tilt filter
// Feeds directed corner samples, then random gyro and accel streams under
// several register settings with random stalls on both sides; a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_tb;
  import imuct_pkg::*;

  localparam int PHASES    = 5;
  localparam int PER_PHASE = 300;
  localparam int LIMIT     = 3000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;   // sample_x, sample_y, sample_z, timestamp_us
  logic [0:0]   s_axis_tuser = '0;   // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;        // angle_x, angle_y, angle_z
  logic [0:0]   m_axis_tuser;        // initialized
  logic         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned  fail_count;
  int unsigned  pending;
  logic         quiet = 1'b0;
  int           stall_left = 0;
  int           cycles = 0;
  logic [47:0]  stamp = '0;

  localparam logic [16:0]        ALPHA_SET[PHASES] = '{17'd655, 17'd0, 17'd65536,
                                                       17'd131071, 17'd40000};
  localparam logic signed [18:0] TRIM_SET[PHASES]  = '{-19'sd13726, 19'sd205887,
                                                       -19'sd205887, -19'sd262144,
                                                       19'sd262143};

  always #1 clk_i = ~clk_i;

  imu_complementary_tilt_filter dut (.*);

  imu_tilt_checker checker_i (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver backpressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [47:0] ts);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {ts, z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off until every predicted result has arrived
  task automatic drain(input int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_comp();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6) return $urandom_range(0, 2 ** 21) - 2 ** 20;
    if (c < 9) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h1;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    int c;
    logic op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: gyro before init, zero vector, extremes, wraps
    send(OP_GYRO,  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 48'd5);
    send(OP_GYRO,  32'h0, 32'h0, 32'h0, 48'hffff_ffff_ffff);
    send(OP_ACCEL, 32'h0, 32'h0, 32'h0, 48'd0);
    send(OP_ACCEL, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 48'd0);
    send(OP_ACCEL, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 48'd0);
    send(OP_ACCEL, 32'h1, 32'h0, 32'hffff_0000, 48'd0);
    send(OP_ACCEL, 32'hffff_ffff, 32'hffff_0000, 32'hffff_0000, 48'd0);
    send(OP_ACCEL, 32'h7fff_ffff, 32'h0, 32'h0, 48'd0);
    send(OP_GYRO,  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 48'h0100_0000_0000);
    send(OP_GYRO,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h0000_0000_0010);
    send(OP_GYRO,  32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 48'h0000_0000_0010);
    send(OP_GYRO,  32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 48'hffff_ffff_ffff);
    send(OP_GYRO,  32'h7fff_ffff, 32'h8000_0000, 32'h0, 48'h0000_0000_0003);
    send(OP_GYRO,  32'h7fff_ffff, 32'h8000_0000, 32'h1, 48'h8000_0000_0000);
    send(OP_ACCEL, 32'h0001_0000, 32'h0009_cccd, 32'h0, 48'd0);
    send(OP_GYRO,  32'h0012_3456, 32'hfff0_0000, 32'h0000_0001, 48'h8000_0000_1388);
    stamp = 48'h8000_0000_1388;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain(8);
        write_reg(REG_BLEND_ALPHA, CFG_DATA_W'(ALPHA_SET[ph]));
        write_reg(REG_ROLL_OFFSET, TRIM_SET[ph]);
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == PHASES - 1 && n >= PER_PHASE / 2) quiet <= 1'b1;
        c = $urandom_range(0, 19);
        if (c < 17) stamp = stamp + $urandom_range(1, 20000);
        else if (c < 19) stamp = 48'({$urandom, $urandom});
        else stamp = stamp - $urandom_range(0, 5000);
        op = 1'($urandom_range(0, 1));
        send(op, pick_comp(), pick_comp(), pick_comp(), stamp);
      end
    end

    drain(250);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/imuct_pkg.sv
design/imuct_cordic.sv
design/imu_complementary_tilt_filter.sv
sim/imu_tilt_checker.sv
sim/imu_complementary_tilt_filter_tb.sv
